FILE: rtl/fcc_pkg.sv
package fcc_pkg;

  localparam int unsigned NSENS   = 8;    // sensor fields carried by one poll
  localparam int unsigned TEMP_W  = 12;   // temperature, signed 1/16 C
  localparam int unsigned PWR_W   = 10;   // power, tenths of a percent
  localparam int unsigned DUTY_W  = 10;   // duty field width on the result
  localparam int unsigned SEL_W   = 9;    // source select: sensors plus external
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 12;
  localparam int unsigned NUM_W   = 22;   // curve numerator and divisor width
  localparam int unsigned POWER_SCALE = 1000;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_BUMP    = 2'd1,
    PH_RUNNING = 2'd2
  } phase_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SRC_SEL     = 3'd0,
    CFG_ENABLED     = 3'd1,
    CFG_START_TEMP  = 3'd2,
    CFG_START_POWER = 3'd3,
    CFG_STOP_TEMP   = 3'd4,
    CFG_FULL_TEMP   = 3'd5,
    CFG_LOW_POWER   = 3'd6,
    CFG_HIGH_POWER  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EVAL,
    ST_CURVE_A,
    ST_CURVE_B,
    ST_SCALE,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } ctl_state_e;

  // What one sensor lane reports to the merge stage.
  typedef struct packed {
    logic  live;  // selected, valid, and no selected invalid sensor above it
    logic  bad;   // selected but flagged invalid
    temp_t temp;
  } lane_res_t;

endpackage

FILE: rtl/fcc_lane.sv
module fcc_lane import fcc_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic [NSENS-1:0] bad_i,
  input  logic             sel_i,
  input  logic             valid_i,
  input  temp_t            temp_i,
  output lane_res_t        res_o
);

  // Sensors with a higher index than this lane.
  localparam logic [NSENS-1:0] ABOVE = {NSENS{1'b1}} << (IDX + 1);

  logic kill;

  // A selected invalid sensor later in the scan resets the max to failsafe,
  // so this reading no longer counts.
  assign kill = |(bad_i & ABOVE);

  always_comb begin
    res_o.live = sel_i & valid_i & ~kill;
    res_o.bad  = sel_i & ~valid_i;
    res_o.temp = temp_i;
  end

endmodule

FILE: rtl/fcc_merge.sv
module fcc_merge import fcc_pkg::*; #(
  parameter int FLOOR_TEMP    = -880,
  parameter int FAILSAFE_TEMP = 2000
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  lane_res_t lanes_i [NSENS],
  input  logic      ext_sel_i,
  input  temp_t     ext_temp_i,
  output temp_t     ctemp_o
);

  localparam temp_t FLOOR_T    = TEMP_W'(FLOOR_TEMP);
  localparam temp_t FAILSAFE_T = TEMP_W'(FAILSAFE_TEMP);

  logic  any_bad;
  temp_t best;
  temp_t ctemp_q;

  always_comb begin
    any_bad = 1'b0;
    for (int i = 0; i < NSENS; i++) begin
      any_bad = any_bad | lanes_i[i].bad;
    end
    best = any_bad ? FAILSAFE_T : FLOOR_T;
    for (int i = 0; i < NSENS; i++) begin
      if (lanes_i[i].live && (lanes_i[i].temp > best)) begin
        best = lanes_i[i].temp;
      end
    end
    if (ext_sel_i && (ext_temp_i > best)) begin
      best = ext_temp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctemp_q <= FLOOR_T;
    end else if (load_i) begin
      ctemp_q <= best;
    end
  end

  assign ctemp_o = ctemp_q;

endmodule

FILE: rtl/fcc_divider.sv
module fcc_divider #(
  parameter int unsigned DVD_W = 38,
  parameter int unsigned DVS_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_d   = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q)
    else $error("divider reports done while still iterating");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a preceding iteration");
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(start_i)) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");
`endif

endmodule

FILE: rtl/fan_curve_controller.sv
// Channel     | Dir | Handshake              | Payload
// ------------+-----+------------------------+---------------------------------------
// s_axis      | in  | tvalid / tready        | one poll: 8 sensors, mask, ext, now_ms
// m_axis      | out | tvalid / tready        | one result: duty, fan state, ctemp
// cfg         | in  | cfg_we_i, no wait      | register index + write data
//
// One poll at a time. A poll that only updates the state machine goes through the
// merge and evaluate states to the result register. A poll that computes a duty
// also goes through the scale step and the bit-serial divider, and through the
// curve steps first when it interpolates the curve rather than a fixed power.
// Reset (async, active low) puts the fan in stopped with zero duty and loads
// the register defaults. A stalled result holds in the output register; the
// next poll is accepted meanwhile and waits only at its own result handoff.
module fan_curve_controller import fcc_pkg::*; #(
  parameter int SENSORS       = 8,
  parameter int PWM_MAX       = 1023,
  parameter int BUMP_MS       = 2000,
  parameter int FLOOR_TEMP    = -880,
  parameter int FAILSAFE_TEMP = 2000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // poll input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [95:0] sensor_temp_0..7 (12b each, sensor 0 lowest), [103:96] valid_mask,
  // [115:104] external_temp, [147:116] now_ms, [151:148] zero
  input  logic [151:0]       s_axis_tdata,
  // result output
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [9:0] target_pwm, [11:10] fan_state, [23:12] control_temp
  output logic [23:0]        m_axis_tdata,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_addr_i,
  input  logic [CFG_D_W-1:0] cfg_wdata_i
);

  localparam int unsigned PW_W  = $clog2(PWM_MAX + 1);
  localparam int unsigned DVD_W = NUM_W + PW_W;
  localparam logic [NSENS-1:0] ACTIVE = NSENS'((1 << SENSORS) - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SEL_W-1:0] src_sel_q;
  logic             en_q;
  temp_t            start_temp_q, stop_temp_q, full_temp_q;
  logic [PWR_W-1:0] start_pwr_q, low_pwr_q, high_pwr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_sel_q    <= '0;
      en_q         <= 1'b1;
      start_temp_q <= TEMP_W'(640);
      start_pwr_q  <= PWR_W'(500);
      stop_temp_q  <= TEMP_W'(480);
      full_temp_q  <= TEMP_W'(960);
      low_pwr_q    <= PWR_W'(200);
      high_pwr_q   <= PWR_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SRC_SEL:     src_sel_q    <= cfg_wdata_i[SEL_W-1:0];
        CFG_ENABLED:     en_q         <= cfg_wdata_i[0];
        CFG_START_TEMP:  start_temp_q <= $signed(cfg_wdata_i[TEMP_W-1:0]);
        CFG_START_POWER: start_pwr_q  <= cfg_wdata_i[PWR_W-1:0];
        CFG_STOP_TEMP:   stop_temp_q  <= $signed(cfg_wdata_i[TEMP_W-1:0]);
        CFG_FULL_TEMP:   full_temp_q  <= $signed(cfg_wdata_i[TEMP_W-1:0]);
        CFG_LOW_POWER:   low_pwr_q    <= cfg_wdata_i[PWR_W-1:0];
        CFG_HIGH_POWER:  high_pwr_q   <= cfg_wdata_i[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Poll capture
  // ---------------------------------------------------------------------------
  temp_t            sens_q [NSENS];
  logic [NSENS-1:0] valid_q;
  temp_t            ext_q;
  logic [31:0]      now_q;
  logic             in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < NSENS; i++) begin
        sens_q[i] <= $signed(s_axis_tdata[i*TEMP_W +: TEMP_W]);
      end
      valid_q <= s_axis_tdata[NSENS*TEMP_W +: NSENS];
      ext_q   <= $signed(s_axis_tdata[NSENS*TEMP_W + NSENS +: TEMP_W]);
      now_q   <= s_axis_tdata[NSENS*TEMP_W + NSENS + TEMP_W +: 32];
    end
  end

  // ---------------------------------------------------------------------------
  // Sensor lanes and merge: control temperature
  // ---------------------------------------------------------------------------
  logic [NSENS-1:0] sel_act;
  logic [NSENS-1:0] bad_vec;
  lane_res_t        lane_res [NSENS];
  logic             merge_load;
  temp_t            ctemp;

  assign sel_act = src_sel_q[NSENS-1:0] & ACTIVE;
  assign bad_vec = sel_act & ~valid_q;

  for (genvar g = 0; g < NSENS; g++) begin : g_lane
    if (g < SENSORS) begin : g_on
      fcc_lane #(.IDX(g)) u_lane (
        .bad_i   (bad_vec),
        .sel_i   (sel_act[g]),
        .valid_i (valid_q[g]),
        .temp_i  (sens_q[g]),
        .res_o   (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  fcc_merge #(
    .FLOOR_TEMP    (FLOOR_TEMP),
    .FAILSAFE_TEMP (FAILSAFE_TEMP)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (merge_load),
    .lanes_i    (lane_res),
    .ext_sel_i  (src_sel_q[SEL_W-1]),
    .ext_temp_i (ext_q),
    .ctemp_o    (ctemp)
  );

  // ---------------------------------------------------------------------------
  // Duty divider
  // ---------------------------------------------------------------------------
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [NUM_W-1:0] den_q, den_d;

  fcc_divider #(.DVD_W(DVD_W), .DVS_W(NUM_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (den_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Control sequencer and fan state machine
  // ---------------------------------------------------------------------------
  ctl_state_e        state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [31:0]       bump_q, bump_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [NUM_W-1:0]  prod_q, prod_d;
  logic              out_load;
  logic              m_valid_q;
  logic [DUTY_W-1:0] out_pwm_q;
  logic [1:0]        out_phase_q;
  temp_t             out_temp_q;

  logic signed [TEMP_W:0] hi_span_s, lo_span_s, range_s;
  logic [31:0]            elapsed;
  logic [DVD_W-1:0]       duty_cap;

  always_comb begin
    hi_span_s = $signed({full_temp_q[TEMP_W-1], full_temp_q}) - $signed({ctemp[TEMP_W-1], ctemp});
    lo_span_s = $signed({ctemp[TEMP_W-1], ctemp}) - $signed({stop_temp_q[TEMP_W-1], stop_temp_q});
    range_s   = $signed({full_temp_q[TEMP_W-1], full_temp_q})
              - $signed({stop_temp_q[TEMP_W-1], stop_temp_q});
    elapsed   = now_q - bump_q;
    duty_cap  = (div_quo > DVD_W'(PWM_MAX)) ? DVD_W'(PWM_MAX) : div_quo;
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    bump_d     = bump_q;
    duty_d     = duty_q;
    num_d      = num_q;
    den_d      = den_q;
    prod_d     = prod_q;
    dvd_d      = dvd_q;
    merge_load = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        merge_load = 1'b1;
        state_d    = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_OUT;
        if (en_q) begin
          unique case (phase_q)
            PH_STOPPED: begin
              if (ctemp >= start_temp_q) begin
                phase_d = PH_BUMP;
                bump_d  = now_q;
                num_d   = NUM_W'(start_pwr_q);
                den_d   = NUM_W'(POWER_SCALE);
                state_d = ST_SCALE;
              end
            end
            PH_BUMP: begin
              if (elapsed >= 32'(BUMP_MS)) begin
                phase_d = PH_RUNNING;
              end
            end
            PH_RUNNING: begin
              // Order matters: end tests come first, so inverted curve points
              // never reach the interpolation.
              if (ctemp < stop_temp_q) begin
                phase_d = PH_STOPPED;
                duty_d  = '0;
              end else if (ctemp <= stop_temp_q) begin
                num_d   = NUM_W'(low_pwr_q);
                den_d   = NUM_W'(POWER_SCALE);
                state_d = ST_SCALE;
              end else if (ctemp >= full_temp_q) begin
                num_d   = NUM_W'(high_pwr_q);
                den_d   = NUM_W'(POWER_SCALE);
                state_d = ST_SCALE;
              end else begin
                state_d = ST_CURVE_A;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CURVE_A: begin
        // low_power * (full - t); divisor = 1000 * (full - stop)
        prod_d  = NUM_W'(low_pwr_q) * NUM_W'(hi_span_s[TEMP_W-1:0]);
        den_d   = NUM_W'(range_s[TEMP_W-1:0]) * NUM_W'(POWER_SCALE);
        state_d = ST_CURVE_B;
      end
      ST_CURVE_B: begin
        // + high_power * (t - stop); fits NUM_W since it interpolates two powers
        num_d   = prod_q + NUM_W'(high_pwr_q) * NUM_W'(lo_span_s[TEMP_W-1:0]);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        dvd_d   = DVD_W'(num_q) * DVD_W'(PWM_MAX);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          duty_d  = duty_cap[DUTY_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_STOPPED;
      bump_q  <= '0;
      duty_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      bump_q  <= bump_d;
      duty_q  <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pwm_q   <= duty_q;
      out_phase_q <= phase_q;
      out_temp_q  <= ctemp;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_temp_q, out_phase_q, out_pwm_q};

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten while stalled");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_stop_goes_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STOPPED && phase_d != PH_STOPPED) |-> (phase_d == PH_BUMP))
    else $error("stopped fan left stopped other than by a start bump");
  a_phase_hold_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_q && state_q == ST_EVAL) |=> $stable(phase_q))
    else $error("fan state changed while disabled");
  a_result_state_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:10] != 2'd3))
    else $error("unused fan state code on result");
`endif

endmodule
